// ----- hw/rtl/rfa_pkg.sv -----
package rfa_pkg;

   localparam int OperandWidth = 16;
   localparam int ProdWidth    = 2 * OperandWidth;
   localparam int MagWidth     = ProdWidth + 1;
   localparam int NumWidth     = 33;
   localparam int DenWidth     = 31;
   localparam int CountWidth   = $clog2(MagWidth + 1);

   localparam logic [2:0] CMD_REDUCE = 3'd0;
   localparam logic [2:0] CMD_ADD    = 3'd1;
   localparam logic [2:0] CMD_SUB    = 3'd2;
   localparam logic [2:0] CMD_MUL    = 3'd3;
   localparam logic [2:0] CMD_DIV    = 3'd4;

   typedef logic [MagWidth-1:0] mag_type;

   // Divider control between sequencer and shared divide unit.
   typedef struct packed {
      logic    start;
      mag_type dividend;
      mag_type divisor;
   } div_req_type;

   typedef struct packed {
      logic    done;
      mag_type quotient;
      mag_type remainder;
   } div_rsp_type;

endpackage

// ----- hw/rtl/rfa_divider.sv -----
module rfa_divider (
   input  logic                clock,
   input  logic                reset,
   input  rfa_pkg::div_req_type div_req,
   output rfa_pkg::div_rsp_type div_rsp
);
   import rfa_pkg::*;

   logic                  busy_ff, busy_in;
   logic [CountWidth-1:0] count_ff, count_in;
   mag_type               quo_ff, quo_in, rem_ff, rem_in, dvs_ff, dvs_in;
   logic                  done_ff, done_in;
   logic [MagWidth:0]     trial;

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      done_in  = 1'b0;
      trial    = {rem_ff, quo_ff[MagWidth-1]} - {1'b0, dvs_ff};
      if (div_req.start) begin
         busy_in  = 1'b1;
         count_in = CountWidth'(MagWidth);
         quo_in   = div_req.dividend;
         rem_in   = '0;
         dvs_in   = div_req.divisor;
      end else if (busy_ff) begin
         // restoring step: one quotient bit per cycle
         if (!trial[MagWidth]) begin
            rem_in = trial[MagWidth-1:0];
            quo_in = {quo_ff[MagWidth-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[MagWidth-2:0], quo_ff[MagWidth-1]};
            quo_in = {quo_ff[MagWidth-2:0], 1'b0};
         end
         count_in = count_ff - 1'b1;
         if (count_ff == CountWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

// ----- hw/rtl/rational_fraction_alu.sv -----
// Sequence: a zero numerator or denominator gives the response straight after the
// products; otherwise the shared 33-step divider runs the Euclid chain, then divides
// numerator and denominator by the gcd.
// Throughput: one request at a time; req_ready is low from acceptance until
// the response is taken, and the next request is taken the cycle after.
// Reset: synchronous, active high; clears the sequencer and the response
// valid flag.
module rational_fraction_alu (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [2:0]                           req_command,
   input  logic signed [rfa_pkg::OperandWidth-1:0] req_a_numerator,
   input  logic signed [rfa_pkg::OperandWidth-1:0] req_a_denominator,
   input  logic signed [rfa_pkg::OperandWidth-1:0] req_b_numerator,
   input  logic signed [rfa_pkg::OperandWidth-1:0] req_b_denominator,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [rfa_pkg::NumWidth-1:0]  rsp_result_numerator,
   output logic [rfa_pkg::DenWidth-1:0]         rsp_result_denominator,
   output logic                                 rsp_error
);
   import rfa_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_MUL1  = 7'b0000010,
      S_MUL2  = 7'b0000100,
      S_GCD   = 7'b0001000,
      S_DIVN  = 7'b0010000,
      S_DIVD  = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   localparam int W = OperandWidth;

   state_type state_ff, state_in;
   logic [2:0]   cmd_ff;
   logic [W-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic         ann_ff, adn_ff, bnn_ff, bdn_ff;
   // products as magnitude and sign
   mag_type p1_ff, p1_in, p2_ff, p2_in;
   logic    s1_ff, s1_in, s2_ff, s2_in;
   mag_type num_ff, num_in, den_ff, den_in, gb_ff, gb_in;
   logic    nneg_ff, nneg_in, dneg_ff, dneg_in;
   mag_type qn_ff, qn_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic [NumWidth-1:0] rn_ff, rn_in;
   logic [DenWidth-1:0] rd_ff, rd_in;
   logic    err_ff, err_in;

   div_req_type div_req;
   div_rsp_type div_rsp;

   // shared multiplier operands
   logic [W-1:0]        mul_x, mul_y;
   logic                mul_sx, mul_sy;
   logic [2*W-1:0]      mul_p;
   logic [MagWidth:0]   sum_t;
   mag_type             addn, addd;
   logic                addneg;

   // first numerator product, computed from held operands in MUL1
   mag_type        p1_calc;
   logic           s1_calc;
   logic [2*W-1:0] p1_raw;

   function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
      mag_of = v[W-1] ? (~v + 1'b1) : v;
   endfunction

   rfa_divider u_div (
      .clock  (clock),
      .reset  (reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   assign mul_p = mul_x * mul_y;

   assign p1_raw  = an_ff * ((cmd_ff == CMD_MUL) ? bn_ff : bd_ff);
   assign p1_calc = MagWidth'(p1_raw);
   assign s1_calc = (p1_raw != '0) &&
                    (ann_ff != ((cmd_ff == CMD_MUL) ? bnn_ff : bdn_ff));

   always_comb begin
      state_in     = state_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      s1_in        = s1_ff;
      s2_in        = s2_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      nneg_in      = nneg_ff;
      dneg_in      = dneg_ff;
      gb_in        = gb_ff;
      qn_in        = qn_ff;
      rn_in        = rn_ff;
      rd_in        = rd_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff;
      div_req      = '0;
      mul_x        = an_ff;
      mul_y        = bd_ff;
      mul_sx       = ann_ff;
      mul_sy       = bdn_ff;
      sum_t        = '0;
      addn         = '0;
      addneg       = 1'b0;
      addd         = '0;

      case (state_ff)
         S_IDLE: begin
            // wait for a request; the accepting edge loads the operands
         end
         S_MUL1: begin
            // first numerator product a*bd (a*bn for multiply)
            p1_in = p1_calc;
            s1_in = s1_calc;
            // second numerator product b*ad
            mul_x = bn_ff; mul_sx = bnn_ff;
            mul_y = ad_ff; mul_sy = adn_ff;
            p2_in = MagWidth'(mul_p);
            s2_in = (mul_p != '0) && ((bnn_ff != adn_ff) ^ (cmd_ff == CMD_SUB));
            state_in = S_MUL2;
         end
         S_MUL2: begin
            // denominator product and numerator combination
            mul_x = ad_ff; mul_sx = adn_ff;
            mul_y = (cmd_ff == CMD_DIV) ? bn_ff : bd_ff;
            mul_sy = (cmd_ff == CMD_DIV) ? bnn_ff : bdn_ff;
            if (s1_ff == s2_ff) begin
               sum_t = {1'b0, p1_ff} + {1'b0, p2_ff};
               addneg = s1_ff;
            end else if (p1_ff >= p2_ff) begin
               sum_t = {1'b0, p1_ff} - {1'b0, p2_ff};
               addneg = s1_ff;
            end else begin
               sum_t = {1'b0, p2_ff} - {1'b0, p1_ff};
               addneg = s2_ff;
            end
            addn = sum_t[MagWidth-1:0];
            addd = MagWidth'(mul_p);
            case (cmd_ff)
               CMD_ADD, CMD_SUB: begin
                  num_in = addn; nneg_in = addneg && (addn != '0);
               end
               CMD_MUL, CMD_DIV: begin
                  num_in = p1_ff; nneg_in = s1_ff;
               end
               default: begin
                  num_in = MagWidth'(mag_of(an_ff)); nneg_in = ann_ff;
                  addd = MagWidth'(mag_of(ad_ff));
               end
            endcase
            den_in = addd;
            dneg_in = (cmd_ff == CMD_ADD || cmd_ff == CMD_SUB || cmd_ff == CMD_MUL ||
                       cmd_ff == CMD_DIV) ? (mul_sx != mul_sy) : adn_ff;
            gb_in = den_in;
            if (den_in == '0) begin
               rn_in = '0; rd_in = DenWidth'(1); err_in = 1'b1;
               state_in = S_OUT; rsp_valid_in = 1'b1;
            end else if (num_in == '0) begin
               rn_in = '0; rd_in = DenWidth'(1); err_in = 1'b0;
               state_in = S_OUT; rsp_valid_in = 1'b1;
            end else begin
               div_req.start = 1'b1;
               div_req.dividend = num_in;
               div_req.divisor = den_in;
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            // Euclid: a, b <- b, a mod b
            if (div_rsp.done) begin
               if (div_rsp.remainder == '0) begin
                  div_req.start = 1'b1;
                  div_req.dividend = num_ff;
                  div_req.divisor = gb_ff;
                  state_in = S_DIVN;
               end else begin
                  gb_in = div_rsp.remainder;
                  div_req.start = 1'b1;
                  div_req.dividend = gb_ff;
                  div_req.divisor = div_rsp.remainder;
               end
            end
         end
         S_DIVN: begin
            if (div_rsp.done) begin
               qn_in = div_rsp.quotient;
               div_req.start = 1'b1;
               div_req.dividend = den_ff;
               div_req.divisor = gb_ff;
               state_in = S_DIVD;
            end
         end
         S_DIVD: begin
            if (div_rsp.done) begin
               rn_in = (nneg_ff != dneg_ff) ? NumWidth'(~qn_ff + 1'b1)
                                            : NumWidth'(qn_ff);
               rd_in = DenWidth'(div_rsp.quotient);
               err_in = 1'b0;
               rsp_valid_in = 1'b1;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // accept request, then advance through the sequence
         if (state_ff == S_IDLE) begin
            state_ff <= (req_valid && req_ready) ? S_MUL1 : S_IDLE;
         end else begin
            state_ff <= state_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      if (state_ff == S_IDLE && req_valid && req_ready) begin
         cmd_ff <= req_command;
         an_ff  <= mag_of(req_a_numerator);   ann_ff <= req_a_numerator[W-1];
         ad_ff  <= mag_of(req_a_denominator); adn_ff <= req_a_denominator[W-1];
         bn_ff  <= mag_of(req_b_numerator);   bnn_ff <= req_b_numerator[W-1];
         bd_ff  <= mag_of(req_b_denominator); bdn_ff <= req_b_denominator[W-1];
      end
      p1_ff   <= p1_in;
      s1_ff   <= s1_in;
      p2_ff   <= p2_in;
      s2_ff   <= s2_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      nneg_ff <= nneg_in;
      dneg_ff <= dneg_in;
      gb_ff   <= gb_in;
      qn_ff   <= qn_in;
      rn_ff   <= rn_in;
      rd_ff   <= rd_in;
      err_ff  <= err_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_result_numerator   = rn_ff;
   assign rsp_result_denominator = rd_ff;
   assign rsp_error              = err_ff;

endmodule

// ----- hw/rtl/rfa_checker.sv -----
module rfa_port_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [rfa_pkg::NumWidth-1:0] rsp_result_numerator,
   input logic [rfa_pkg::DenWidth-1:0] rsp_result_denominator,
   input logic                         rsp_error
);
   import rfa_pkg::*;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken while response pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("request taken while busy");

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_result_denominator != '0) else $error("zero denominator");

   a_err_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error) |-> (rsp_result_numerator == '0 &&
      rsp_result_denominator == DenWidth'(1))) else $error("error result not 0/1");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_result_numerator)))
      else $error("response dropped");

endmodule

bind rational_fraction_alu rfa_port_checker u_rfa_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_result_numerator(rsp_result_numerator),
   .rsp_result_denominator(rsp_result_denominator), .rsp_error(rsp_error)
);

// ----- dv/rfa_checker.sv -----
`timescale 1ns / 1ps
module rfa_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic [2:0]                            req_command,
   input  logic signed [rfa_pkg::OperandWidth-1:0] req_a_numerator,
   input  logic signed [rfa_pkg::OperandWidth-1:0] req_a_denominator,
   input  logic signed [rfa_pkg::OperandWidth-1:0] req_b_numerator,
   input  logic signed [rfa_pkg::OperandWidth-1:0] req_b_denominator,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic signed [rfa_pkg::NumWidth-1:0]   rsp_result_numerator,
   input  logic [rfa_pkg::DenWidth-1:0]          rsp_result_denominator,
   input  logic                                  rsp_error,
   output int                                    fail_count,
   output int                                    pending_count
);
   import rfa_pkg::*;

   typedef struct {
      logic signed [NumWidth-1:0] num;
      logic [DenWidth-1:0]        den;
      logic                       err;
   } fraction_type;

   fraction_type reduced_q[$];

   function automatic longint unsigned gcd_of(longint unsigned a, longint unsigned b);
      longint unsigned t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   // Products fit easily in 64 bits; form them signed, reduce their magnitudes.
   function automatic fraction_type reduce_fraction(logic [2:0] cmd, longint an,
                                                   longint ad, longint bn, longint bd);
      fraction_type f;
      longint num, den;
      longint unsigned nm, dm, g;
      case (cmd)
         CMD_ADD: begin num = an * bd + bn * ad; den = ad * bd; end
         CMD_SUB: begin num = an * bd - bn * ad; den = ad * bd; end
         CMD_MUL: begin num = an * bn; den = ad * bd; end
         CMD_DIV: begin num = an * bd; den = ad * bn; end
         default: begin num = an; den = ad; end
      endcase
      f.num = '0;
      f.den = DenWidth'(1);
      f.err = (den == 0);
      if (den != 0 && num != 0) begin
         nm = (num < 0) ? -num : num;
         dm = (den < 0) ? -den : den;
         g = gcd_of(nm, dm);
         nm = nm / g;
         f.num = NumWidth'(((num < 0) != (den < 0)) ? -nm : nm);
         f.den = DenWidth'(dm / g);
      end
      return f;
   endfunction

   always @(posedge clock) begin
      fraction_type e;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready)
            reduced_q.push_back(reduce_fraction(req_command, req_a_numerator,
               req_a_denominator, req_b_numerator, req_b_denominator));
         if (rsp_valid && rsp_ready) begin
            if (reduced_q.size() == 0) begin
               $display("%0t: unexpected response %0d/%0d err %0b", $time,
                  rsp_result_numerator, rsp_result_denominator, rsp_error);
               fail_count <= fail_count + 1;
            end else begin
               e = reduced_q.pop_front();
               if (e.num !== rsp_result_numerator || e.den !== rsp_result_denominator
                   || e.err !== rsp_error) begin
                  $display("%0t: expected %0d/%0d err %0b, got %0d/%0d err %0b", $time,
                     e.num, e.den, e.err, rsp_result_numerator,
                     rsp_result_denominator, rsp_error);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending_count <= reduced_q.size();
   end
endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
module tb;
   import rfa_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [2:0] req_command = CMD_REDUCE;
   logic signed [OperandWidth-1:0] req_a_numerator = '0;
   logic signed [OperandWidth-1:0] req_a_denominator = OperandWidth'(1);
   logic signed [OperandWidth-1:0] req_b_numerator = '0;
   logic signed [OperandWidth-1:0] req_b_denominator = OperandWidth'(1);
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [NumWidth-1:0] rsp_result_numerator;
   logic [DenWidth-1:0] rsp_result_denominator;
   logic rsp_error;
   int fail_count;
   int pending_count;

   always #1 clock = ~clock;

   rational_fraction_alu i_dut (.*);
   rfa_checker i_checker (.*);

   // Pick an operand: mostly small values, sometimes an extreme or full-range one.
   function automatic logic [OperandWidth-1:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return OperandWidth'(16'h8000);
         1: return OperandWidth'(16'h7fff);
         2: return '0;
         3, 4: return OperandWidth'($urandom);
         default: return OperandWidth'($urandom_range(0, 40) - 20);
      endcase
   endfunction

   // Present one request at a falling edge and hold it until it is accepted.
   // Valid stays high afterwards; the caller drops it before a gap.
   task automatic send_request(int cmd, int an, int ad, int bn, int bd);
      logic ready_seen;
      req_command       <= 3'(cmd);
      req_a_numerator   <= OperandWidth'(an);
      req_a_denominator <= OperandWidth'(ad);
      req_b_numerator   <= OperandWidth'(bn);
      req_b_denominator <= OperandWidth'(bd);
      req_valid         <= 1;
      do begin
         // ready only moves at a rising edge, so this is what the edge sees
         ready_seen = req_ready;
         @(posedge clock);
         if (!ready_seen)
            @(negedge clock);
      end while (!ready_seen);
      @(negedge clock);
   endtask

   // Receiver stalls on its own pattern, with quiet stretches.
   always @(negedge clock) begin
      if ((($time / 2000) % 3) == 0)
         rsp_ready <= 1;
      else
         rsp_ready <= ($urandom_range(0, 3) != 0);
   end

   initial begin
      int burst;
      int gap;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // Directed: extremes, every command, zero denominators and numerators, unused codes.
      send_request(CMD_REDUCE, 16'h8000, 16'h8000, 0, 1);
      send_request(CMD_REDUCE, 16'h7fff, 16'h8000, 0, 1);
      send_request(CMD_REDUCE, 6, 16'hfffc, 0, 1);
      send_request(CMD_REDUCE, 5, 0, 0, 1);
      send_request(CMD_REDUCE, 0, 16'hfff9, 0, 1);
      send_request(CMD_ADD, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
      send_request(CMD_ADD, 1, 2, 16'hffff, 2);
      send_request(CMD_SUB, 16'h8000, 16'h8000, 16'h7fff, 16'h8000);
      send_request(CMD_SUB, 3, 4, 3, 4);
      send_request(CMD_SUB, 16'h8000, 1, 16'h7fff, 16'hffff);
      send_request(CMD_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_request(CMD_MUL, 16'h7fff, 1, 16'h8000, 16'hffff);
      send_request(CMD_MUL, 2, 0, 3, 5);
      send_request(CMD_DIV, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
      send_request(CMD_DIV, 4, 5, 0, 3);
      send_request(CMD_DIV, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
      send_request(3'd5, 10, 16'hfff6, 1, 1);
      send_request(3'd6, 16'hffff, 0, 1, 1);
      send_request(3'd7, 16'h7fff, 16'h7ffe, 1, 1);
      // Hold off until everything in flight has drained.
      req_valid <= 0;
      wait (pending_count == 0);
      @(negedge clock);
      // Random: bursts with gaps between them.
      for (int n = 0; n < 1300; n += burst) begin
         burst = $urandom_range(1, 12);
         for (int k = 0; k < burst; k++)
            send_request($urandom_range(0, 9) == 0 ? $urandom_range(5, 7)
                         : $urandom_range(0, 4), pick_operand(), pick_operand(),
                         pick_operand(), pick_operand());
         gap = $urandom_range(0, 8);
         if (gap != 0) begin
            req_valid <= 0;
            repeat (gap) @(negedge clock);
         end
      end
      req_valid <= 0;
      wait (pending_count == 0);
      repeat (400) @(posedge clock);
      if (fail_count == 0)
         $display("PASS rational_fraction_alu");
      else
         $display("FAIL rational_fraction_alu");
      $finish;
   end

   initial begin
      #25000000;
      $display("FAIL rational_fraction_alu");
      $finish;
   end
endmodule

// ----- sim.f -----
hw/rtl/rfa_pkg.sv
hw/rtl/rfa_divider.sv
hw/rtl/rational_fraction_alu.sv
hw/rtl/rfa_checker.sv
dv/rfa_checker.sv
dv/tb.sv
